// File: rtl/gblf_pkg.sv
// Shared types and constants for the GNSS binary log framer.
package gblf_pkg;

   localparam int MAX_HEADER  = 32;
   localparam int MAX_PAYLOAD = 512;

   // Counter covers header byte positions and payload indexes.
   localparam int HDR_CNT_W = $clog2(MAX_HEADER + 1);
   localparam int PAY_CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int CNT_W     = (HDR_CNT_W > PAY_CNT_W) ? HDR_CNT_W : PAY_CNT_W;
   // Compare width: holds the counter, a 16-bit length and the sum of one.
   localparam int CMP_W     = (CNT_W > 16) ? CNT_W + 1 : 17;

   localparam logic [7:0] SYNC_A = 8'hAA;
   localparam logic [7:0] SYNC_B = 8'h44;
   localparam logic [7:0] SYNC_C = 8'h12;

   localparam logic [15:0] ID_POSITION = 16'd42;
   localparam logic [15:0] ID_VELOCITY = 16'd99;

   localparam int HDR_ID_LO  = 4;
   localparam int HDR_ID_HI  = 5;
   localparam int HDR_LEN_LO = 8;
   localparam int HDR_LEN_HI = 9;

   typedef enum logic [2:0] {
      CLS_SYNC    = 3'd0,
      CLS_HEADER  = 3'd1,
      CLS_PAYLOAD = 3'd2,
      CLS_CRC     = 3'd3,
      CLS_DROP    = 3'd4
   } byte_class_type;

   typedef struct packed {
      logic           pair_ready;
      logic [31:0]    crc_received;
      logic [15:0]    message_length;
      logic [15:0]    message_id;
      logic           frame_done;
      logic [8:0]     payload_index;
      byte_class_type byte_class;
   } result_type;

endpackage

// File: rtl/gnss_binary_log_framer_unit.sv
// Top level of the GNSS binary log framer: byte stream in, classified bytes out.
//
//   channel   dir   beat carries
//   -------   ---   ---------------------------------------------------------
//   req_*     in    one received byte of the receiver's serial stream
//   rsp_*     out   byte class, payload index, header id/length, crc, flags
//
// One byte is taken per cycle while req_tready is high; each accepted byte
// yields exactly one result beat, registered in the result register (or the
// skid entry when the result side is stalled). The throughput of one beat per
// cycle is set by the parser result feeding the result register directly.
// Reset is synchronous and active high; it returns the parser to the hunt
// for the first sync byte and empties the result register and skid entry.
// When rsp_tready is low the skid entry absorbs one more beat; req_tready
// then drops until the result register drains.
module gnss_binary_log_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] byte_class, [11:3] payload_index, [27:12] message_id,
   // [43:28] message_length, [75:44] crc_received, [79:76] zero
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast,   // frame_done
   output logic        rsp_tuser    // [0] pair_ready
);

   gblf_pkg::result_type step_result;
   gblf_pkg::result_type rsp_result;
   logic                 req_take;

   // A beat is taken only when the skid entry has room.
   assign req_take = req_tvalid && req_tready;

   gblf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .beat_take (req_take),
      .rx_byte   (req_tdata),
      .result    (step_result)
   );

   gblf_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   // Pack the result fields, highest field first.
   assign rsp_tdata = {4'd0,
                       rsp_result.crc_received,
                       rsp_result.message_length,
                       rsp_result.message_id,
                       rsp_result.payload_index,
                       rsp_result.byte_class};
   assign rsp_tlast = rsp_result.frame_done;
   assign rsp_tuser = rsp_result.pair_ready;

endmodule

// File: rtl/gblf_parser.sv
// Frame parser: state update and per-byte result for one received byte.
module gblf_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_take,
   input  logic [7:0]          rx_byte,
   output gblf_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_SYNC3   = 4'd2,
      PH_HLEN    = 4'd3,
      PH_HDATA   = 4'd4,
      PH_PAYLOAD = 4'd5,
      PH_CRC1    = 4'd6,
      PH_CRC2    = 4'd7,
      PH_CRC3    = 4'd8,
      PH_CRC4    = 4'd9
   } phase_type;

   localparam int CNT_W = gblf_pkg::CNT_W;
   localparam int CMP_W = gblf_pkg::CMP_W;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        hsize_ff, hsize_in;
   logic [15:0]       id_ff, id_in;
   logic [15:0]       len_ff, len_in;
   logic [31:0]       crc_ff, crc_in;
   logic              seen_pos_ff, seen_pos_in;
   logic              seen_vel_ff, seen_vel_in;

   logic [CMP_W-1:0]  count_x;
   logic [CMP_W-1:0]  count_inc;
   logic [CMP_W-1:0]  hsize_x;
   logic [CMP_W-1:0]  len_x;
   logic              pos_hit;
   logic              vel_hit;

   assign count_x   = CMP_W'(count_ff);
   assign count_inc = count_x + CMP_W'(1);
   assign hsize_x   = CMP_W'(hsize_ff);
   assign pos_hit   = seen_pos_ff || (id_ff == gblf_pkg::ID_POSITION);
   assign vel_hit   = seen_vel_ff || (id_ff == gblf_pkg::ID_VELOCITY);

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      hsize_in    = hsize_ff;
      id_in       = id_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      seen_pos_in = seen_pos_ff;
      seen_vel_in = seen_vel_ff;
      len_x       = CMP_W'(len_ff);

      result.byte_class    = gblf_pkg::CLS_SYNC;
      result.payload_index = 9'd0;
      result.frame_done    = 1'b0;
      result.pair_ready    = 1'b0;

      case (phase_ff)
         PH_SYNC1: begin
            phase_in = (rx_byte == gblf_pkg::SYNC_A) ? PH_SYNC2 : PH_SYNC1;
         end
         PH_SYNC2: begin
            phase_in = (rx_byte == gblf_pkg::SYNC_B) ? PH_SYNC3 : PH_SYNC1;
         end
         PH_SYNC3: begin
            phase_in = (rx_byte == gblf_pkg::SYNC_C) ? PH_HLEN : PH_SYNC1;
         end
         PH_HLEN: begin
            result.byte_class = gblf_pkg::CLS_HEADER;
            hsize_in = rx_byte;
            id_in    = 16'd0;
            len_in   = 16'd0;
            count_in = CNT_W'(gblf_pkg::HDR_ID_LO);
            phase_in = PH_HDATA;
         end
         PH_HDATA: begin
            if (count_x >= CMP_W'(gblf_pkg::MAX_HEADER)) begin
               result.byte_class = gblf_pkg::CLS_DROP;
               phase_in = PH_SYNC1;
            end else begin
               result.byte_class = gblf_pkg::CLS_HEADER;
               if (count_x == CMP_W'(gblf_pkg::HDR_ID_LO)) begin
                  id_in = {id_ff[15:8], rx_byte};
               end else if (count_x == CMP_W'(gblf_pkg::HDR_ID_HI)) begin
                  id_in = {rx_byte, id_ff[7:0]};
               end else if (count_x == CMP_W'(gblf_pkg::HDR_LEN_LO)) begin
                  len_in = {len_ff[15:8], rx_byte};
               end else if (count_x == CMP_W'(gblf_pkg::HDR_LEN_HI)) begin
                  len_in = {rx_byte, len_ff[7:0]};
               end
               count_in = count_inc[CNT_W-1:0];
               if (count_inc >= hsize_x) begin
                  count_in = '0;
                  phase_in = (len_in == 16'd0) ? PH_CRC1 : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (count_x >= CMP_W'(gblf_pkg::MAX_PAYLOAD)) begin
               result.byte_class = gblf_pkg::CLS_DROP;
               phase_in = PH_SYNC1;
            end else begin
               result.byte_class    = gblf_pkg::CLS_PAYLOAD;
               result.payload_index = count_x[8:0];
               count_in = count_inc[CNT_W-1:0];
               if (count_inc >= len_x) begin
                  phase_in = PH_CRC1;
               end
            end
         end
         PH_CRC1: begin
            result.byte_class = gblf_pkg::CLS_CRC;
            crc_in   = {24'd0, rx_byte};
            phase_in = PH_CRC2;
         end
         PH_CRC2: begin
            result.byte_class = gblf_pkg::CLS_CRC;
            crc_in   = {crc_ff[31:16], crc_ff[15:8] | rx_byte, crc_ff[7:0]};
            phase_in = PH_CRC3;
         end
         PH_CRC3: begin
            result.byte_class = gblf_pkg::CLS_CRC;
            crc_in   = {crc_ff[31:24], crc_ff[23:16] | rx_byte, crc_ff[15:0]};
            phase_in = PH_CRC4;
         end
         PH_CRC4: begin
            result.byte_class = gblf_pkg::CLS_CRC;
            result.frame_done = 1'b1;
            crc_in   = {crc_ff[31:24] | rx_byte, crc_ff[23:0]};
            phase_in = PH_SYNC1;
            // Clear both flags once a pair of logs has completed.
            if (pos_hit && vel_hit) begin
               seen_pos_in       = 1'b0;
               seen_vel_in       = 1'b0;
               result.pair_ready = 1'b1;
            end else begin
               seen_pos_in = pos_hit;
               seen_vel_in = vel_hit;
            end
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase

      result.message_id     = id_in;
      result.message_length = len_in;
      result.crc_received   = crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC1;
         count_ff    <= '0;
         hsize_ff    <= 8'd0;
         id_ff       <= 16'd0;
         len_ff      <= 16'd0;
         crc_ff      <= 32'd0;
         seen_pos_ff <= 1'b0;
         seen_vel_ff <= 1'b0;
      end else if (beat_take) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         hsize_ff    <= hsize_in;
         id_ff       <= id_in;
         len_ff      <= len_in;
         crc_ff      <= crc_in;
         seen_pos_ff <= seen_pos_in;
         seen_vel_ff <= seen_vel_in;
      end
   end

endmodule

// File: rtl/gblf_skid.sv
// Result register with a skid entry so the input side keeps a registered ready.
module gblf_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gblf_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gblf_pkg::result_type out_data
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   gblf_pkg::result_type main_data_ff;
   gblf_pkg::result_type skid_data_ff;
   logic                 in_fire;
   logic                 main_free;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && !skid_valid_ff;
   assign main_free = !main_valid_ff || out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         // Refill the result register, oldest beat first.
         main_valid_ff <= skid_valid_ff || in_fire;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (!main_free && in_fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

// File: rtl/gblf_checker.sv
// Port-level checks for the framer top level, bound to it.
module gblf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   logic [2:0] cls;
   logic       in_beat;

   assign cls     = rsp_tdata[2:0];
   assign in_beat = req_tvalid && req_tready;

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // After every accepted byte a result beat is valid on the next cycle.
   a_in_to_out: assert property (@(posedge clock) disable iff (reset)
      in_beat |=> rsp_tvalid)
      else $error("accepted byte produced no result beat");

   // Frame end only on a crc byte.
   a_done_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> cls == gblf_pkg::CLS_CRC)
      else $error("frame end on a non-crc byte");

   // A pair is reported only at a frame end.
   a_pair_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("pair flag outside a frame end");

   // Payload index is zero outside the payload.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cls != gblf_pkg::CLS_PAYLOAD |-> rsp_tdata[11:3] == 9'd0)
      else $error("payload index set outside payload");

endmodule

bind gnss_binary_log_framer_unit gblf_checker u_gblf_checker (.*);

// File: tb/gnss_binary_log_framer_unit_test.sv
// Self-checking testbench for the GNSS binary log framer unit.
module gnss_binary_log_framer_unit_test;

   // Cycles with no beat on either channel before the run is declared hung.
   localparam int QUIET_LIMIT = 2000;
   // Input bytes sent so far at which the idling phase ends and the run ends.
   localparam int RANDOM_GOAL = 900;
   localparam int STEADY_GOAL = 1050;
   // Print no more than this many mismatch lines; keep counting past it.
   localparam int REPORT_CAP  = 40;

   // Parser phases of the framer, as tracked by the testbench copy.
   typedef enum logic [3:0] {
      HUNT_A, HUNT_B, HUNT_C, TAKE_HLEN, TAKE_HDR, TAKE_PAYLOAD,
      TAKE_CRC0, TAKE_CRC1, TAKE_CRC2, TAKE_CRC3
   } framer_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [2:0] byte_class, [11:3] payload_index, [27:12] message_id,
   // [43:28] message_length, [75:44] crc_received, [79:76] zero
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;        // frame_done
   logic        rsp_tuser;        // [0] pair_ready

   gnss_binary_log_framer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Testbench copy of the framer state.
   framer_phase_type phase;
   logic [15:0]      pos_count;
   logic [7:0]       hdr_len;
   logic [15:0]      cur_id;
   logic [15:0]      cur_len;
   logic [31:0]      crc_word;
   logic             got_position;
   logic             got_velocity;

   gblf_pkg::result_type classified_queue[$];   // classified bytes not yet seen on rsp
   int  fail_count = 0;
   int  quiet_cycles = 0;
   int  frame_items = 0;   // input bytes handed to the driver so far
   bit  idling_on = 1'b1;
   int  stall_left = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < REPORT_CAP)
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got,
                  want);
      fail_count++;
   endtask

   // Advance the framer copy by one received byte; return the beat it yields.
   function automatic gblf_pkg::result_type classify_rx_byte(input logic [7:0] rx);
      gblf_pkg::result_type r;
      r = '0;
      r.byte_class = gblf_pkg::CLS_SYNC;
      case (phase)
         HUNT_B: phase = (rx == gblf_pkg::SYNC_B) ? HUNT_C : HUNT_A;
         HUNT_C: phase = (rx == gblf_pkg::SYNC_C) ? TAKE_HLEN : HUNT_A;
         TAKE_HLEN: begin
            // A new header clears the id and length fields.
            r.byte_class = gblf_pkg::CLS_HEADER;
            hdr_len   = rx;
            cur_id    = '0;
            cur_len   = '0;
            pos_count = 16'd4;
            phase     = TAKE_HDR;
         end
         TAKE_HDR: begin
            if (pos_count >= gblf_pkg::MAX_HEADER) begin
               r.byte_class = gblf_pkg::CLS_DROP;
               phase = HUNT_A;
            end else begin
               r.byte_class = gblf_pkg::CLS_HEADER;
               case (pos_count)
                  gblf_pkg::HDR_ID_LO:  cur_id[7:0]   = rx;
                  gblf_pkg::HDR_ID_HI:  cur_id[15:8]  = rx;
                  gblf_pkg::HDR_LEN_LO: cur_len[7:0]  = rx;
                  gblf_pkg::HDR_LEN_HI: cur_len[15:8] = rx;
                  default: ;
               endcase
               pos_count = pos_count + 16'd1;
               // At least one header data byte is always taken.
               if (pos_count >= hdr_len) begin
                  pos_count = '0;
                  phase = (cur_len == 16'd0) ? TAKE_CRC0 : TAKE_PAYLOAD;
               end
            end
         end
         TAKE_PAYLOAD: begin
            if (pos_count >= gblf_pkg::MAX_PAYLOAD) begin
               r.byte_class = gblf_pkg::CLS_DROP;
               phase = HUNT_A;
            end else begin
               r.byte_class    = gblf_pkg::CLS_PAYLOAD;
               r.payload_index = pos_count[8:0];
               pos_count = pos_count + 16'd1;
               if (pos_count >= cur_len) phase = TAKE_CRC0;
            end
         end
         TAKE_CRC0: begin
            r.byte_class = gblf_pkg::CLS_CRC;
            crc_word = {24'd0, rx};
            phase = TAKE_CRC1;
         end
         TAKE_CRC1: begin
            r.byte_class = gblf_pkg::CLS_CRC;
            crc_word = crc_word | ({24'd0, rx} << 8);
            phase = TAKE_CRC2;
         end
         TAKE_CRC2: begin
            r.byte_class = gblf_pkg::CLS_CRC;
            crc_word = crc_word | ({24'd0, rx} << 16);
            phase = TAKE_CRC3;
         end
         TAKE_CRC3: begin
            r.byte_class = gblf_pkg::CLS_CRC;
            crc_word = crc_word | ({24'd0, rx} << 24);
            phase = HUNT_A;
            r.frame_done = 1'b1;
            if (cur_id == gblf_pkg::ID_POSITION) got_position = 1'b1;
            if (cur_id == gblf_pkg::ID_VELOCITY) got_velocity = 1'b1;
            // Both logs seen: flag the pair and start collecting a new one.
            if (got_position && got_velocity) begin
               got_position = 1'b0;
               got_velocity = 1'b0;
               r.pair_ready = 1'b1;
            end
         end
         default: phase = (rx == gblf_pkg::SYNC_A) ? HUNT_B : HUNT_A;
      endcase
      r.message_id     = cur_id;
      r.message_length = cur_len;
      r.crc_received   = crc_word;
      return r;
   endfunction

   // Monitor both channels at the rising edge: check the rsp beat first, then
   // predict for the req beat, so a beat can never match its own input.
   always @(posedge clock) begin : monitor
      gblf_pkg::result_type want;
      bit                   moved;
      if (reset) begin
         phase        = HUNT_A;
         pos_count    = '0;
         hdr_len      = '0;
         cur_id       = '0;
         cur_len      = '0;
         crc_word     = '0;
         got_position = 1'b0;
         got_velocity = 1'b0;
         classified_queue.delete();
         quiet_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (classified_queue.size() == 0) begin
               report_mismatch("rsp beat with nothing expected", rsp_tdata[31:0], 32'd0);
            end else begin
               want = classified_queue.pop_front();
               if (rsp_tdata[2:0] !== want.byte_class)
                  report_mismatch("byte_class", 32'(rsp_tdata[2:0]),
                                  32'(want.byte_class));
               if (rsp_tdata[11:3] !== want.payload_index)
                  report_mismatch("payload_index", 32'(rsp_tdata[11:3]),
                                  32'(want.payload_index));
               if (rsp_tdata[27:12] !== want.message_id)
                  report_mismatch("message_id", 32'(rsp_tdata[27:12]),
                                  32'(want.message_id));
               if (rsp_tdata[43:28] !== want.message_length)
                  report_mismatch("message_length", 32'(rsp_tdata[43:28]),
                                  32'(want.message_length));
               if (rsp_tdata[75:44] !== want.crc_received)
                  report_mismatch("crc_received", rsp_tdata[75:44], want.crc_received);
               if (rsp_tlast !== want.frame_done)
                  report_mismatch("frame_done", 32'(rsp_tlast), 32'(want.frame_done));
               if (rsp_tuser !== want.pair_ready)
                  report_mismatch("pair_ready", 32'(rsp_tuser), 32'(want.pair_ready));
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            classified_queue.push_back(classify_rx_byte(req_tdata));
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // Stall the result side in random bursts while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // End the run if no beat moves for too long.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // Drive one byte; hold it until accepted and return at the falling edge.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      frame_items++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Build one binary log and send it. The header stops at a header overflow
   // and the payload at a payload overflow; a positive cut truncates the log.
   task automatic send_frame(input logic [7:0] hlen, input logic [15:0] id,
                             input logic [15:0] len, input int cut);
      logic [7:0]  beats[$];
      logic [15:0] eff_len;
      int          pos;
      bit          dropped;
      beats   = '{gblf_pkg::SYNC_A, gblf_pkg::SYNC_B, gblf_pkg::SYNC_C, hlen};
      eff_len = '0;
      dropped = 1'b0;
      pos     = 4;
      do begin
         if (pos == gblf_pkg::MAX_HEADER) begin
            beats.push_back(8'($urandom));
            dropped = 1'b1;
         end else begin
            case (pos)
               gblf_pkg::HDR_ID_LO:  beats.push_back(id[7:0]);
               gblf_pkg::HDR_ID_HI:  beats.push_back(id[15:8]);
               gblf_pkg::HDR_LEN_LO: begin
                  beats.push_back(len[7:0]);
                  eff_len[7:0] = len[7:0];
               end
               gblf_pkg::HDR_LEN_HI: begin
                  beats.push_back(len[15:8]);
                  eff_len[15:8] = len[15:8];
               end
               default: beats.push_back(8'($urandom));
            endcase
         end
         pos++;
      end while (!dropped && pos < hlen);
      if (!dropped) begin
         if (eff_len > gblf_pkg::MAX_PAYLOAD) begin
            repeat (gblf_pkg::MAX_PAYLOAD + 1) beats.push_back(8'($urandom));
            dropped = 1'b1;
         end else begin
            repeat (eff_len) beats.push_back(8'($urandom));
            repeat (4) beats.push_back(8'($urandom));
         end
      end
      if (cut > 0)
         while (beats.size() > cut) void'(beats.pop_back());
      foreach (beats[i]) send_byte(beats[i]);
   endtask

   // Wrong second and third sync bytes; a failed second byte is not retried
   // as a first sync byte. Also carries the rx_byte extremes.
   task automatic test_sync_hunt();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(gblf_pkg::SYNC_A);
      send_byte(gblf_pkg::SYNC_B);
      send_byte(8'h13);
      send_byte(gblf_pkg::SYNC_A);
      send_byte(gblf_pkg::SYNC_A);
      send_byte(gblf_pkg::SYNC_B);
      send_byte(gblf_pkg::SYNC_A);
      send_byte(8'h00);
   endtask

   // Short header lengths with zero-length logs: a position log and then a
   // velocity log, which together raise the pair flag.
   task automatic test_short_frames();
      send_frame(8'd0, gblf_pkg::ID_POSITION, 16'd0, 0);
      send_frame(8'd5, gblf_pkg::ID_VELOCITY, 16'd0, 0);
   endtask

   // Header too long for the store, then a payload too long for the store.
   task automatic test_store_overflow();
      send_frame(8'd40, 16'($urandom), 16'($urandom), 0);
      send_frame(8'd28, 16'hFFFF, 16'hFFFF, 0);
   endtask

   // Mostly well-formed logs with random content, mixed with truncated logs,
   // broken sync and noise, until the byte count reaches the goal.
   task automatic test_random_frames(input int goal);
      logic [7:0]  hlen;
      logic [15:0] id;
      logic [15:0] len;
      int          pick;
      while (frame_items < goal) begin
         case ($urandom_range(0, 9))
            0, 1:    hlen = 8'($urandom_range(0, 10));
            2:       hlen = 8'($urandom_range(11, 32));
            3:       hlen = 8'($urandom_range(33, 255));
            default: hlen = 8'd28;
         endcase
         case ($urandom_range(0, 3))
            0:       id = gblf_pkg::ID_POSITION;
            1:       id = gblf_pkg::ID_VELOCITY;
            default: id = 16'($urandom);
         endcase
         len  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            send_frame(hlen, id, len, 0);
         end else if (pick < 17) begin
            send_frame(hlen, id, len, $urandom_range(1, 14));
         end else if (pick < 18) begin
            send_byte(gblf_pkg::SYNC_A);
            if ($urandom_range(0, 1) == 0) send_byte(gblf_pkg::SYNC_B);
            send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      int guard;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_sync_hunt();
      test_short_frames();
      test_store_overflow();
      test_random_frames(RANDOM_GOAL);
      // Drop all idling for the tail of the run: full rate on both sides.
      idling_on = 1'b0;
      test_random_frames(STEADY_GOAL);
      req_tvalid <= 1'b0;

      guard = 0;
      while (classified_queue.size() != 0 && guard < QUIET_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (classified_queue.size() != 0)
         report_mismatch("beats never delivered", classified_queue.size(), 32'd0);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
